/* rtl/rpi_pkg.sv */
`default_nettype none

package rpi_pkg;

  localparam int unsigned COORD_W       = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned EPS_W         = 17;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  // t is nonnegative and below 2^31, so the divider produces this many bits
  localparam int unsigned Q_W = COORD_W - 1;

  // front end (4 stages) + one stage per quotient bit + point stages (2)
  localparam int unsigned PIPE_LAT = 6 + Q_W;

  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;
  localparam logic        REG_EPS  = 1'b0;

  typedef enum logic [1:0] {
    MISS_NONE   = 2'd0,
    MISS_FACING = 2'd1,
    MISS_BEHIND = 2'd2
  } miss_e;

endpackage

`default_nettype wire

/* rtl/ray_plane_intersection.sv */
// Pipeline from start to done_o: 4 dot-product and classify stages, 31 restoring-divider
// stages, 2 point stages.
// Throughput: one transfer per cycle; busy stays low, the receiver cannot stall.
// Reset: rst_ni clears all valid bits and loads facing_epsilon with 1.
`default_nettype none

module ray_plane_intersection #(
  parameter int unsigned FRAC_BITS = rpi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output      logic                             busy,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] ray_start_x_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] ray_start_y_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] ray_start_z_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] ray_dir_x_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] ray_dir_y_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] ray_dir_z_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] plane_normal_x_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] plane_normal_y_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] plane_normal_z_i,
  input  wire logic signed [rpi_pkg::COORD_W-1:0] plane_offset_i,
  output      logic                             done_o,
  output      logic                             hit_o,
  output      logic [1:0]                       miss_reason_o,
  output      logic signed [rpi_pkg::COORD_W-1:0] hit_distance_o,
  output      logic signed [rpi_pkg::COORD_W-1:0] point_x_o,
  output      logic signed [rpi_pkg::COORD_W-1:0] point_y_o,
  output      logic signed [rpi_pkg::COORD_W-1:0] point_z_o,
  output      logic                             saturated_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rpi_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [rpi_pkg::DATA_W-1:0]       pwdata,
  output      logic [rpi_pkg::DATA_W-1:0]       prdata,
  output      logic                             pready
);

  localparam int unsigned CW     = rpi_pkg::COORD_W;
  localparam int unsigned QW     = rpi_pkg::Q_W;
  localparam int unsigned EW     = rpi_pkg::EPS_W;
  localparam int unsigned PROD_W = 2 * CW;
  localparam int unsigned SH_W   = PROD_W - FRAC_BITS;
  localparam int unsigned DOT_W  = SH_W + 2;
  localparam int unsigned REM_W  = DOT_W + 1;
  localparam int unsigned SHF    = QW - FRAC_BITS;
  localparam int unsigned R0_W   = REM_W + FRAC_BITS - QW;

  typedef struct packed {
    logic [2:0][CW-1:0] start;
    logic [2:0][CW-1:0] dir;
    rpi_pkg::miss_e     miss;
    logic               ovf;
  } side_t;

  // ---------------- configuration ----------------
  logic [EW-1:0] eps_q;
  logic          cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rpi_pkg::REG_EPS);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rpi_pkg::REG_EPS) ? {{(rpi_pkg::DATA_W-EW){1'b0}}, eps_q}
                                                 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= rpi_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      eps_q <= pwdata[EW-1:0];
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- stage 1: products ----------------
  logic signed [CW-1:0] start_a [3];
  logic signed [CW-1:0] dir_a   [3];
  logic signed [CW-1:0] nrm_a   [3];

  assign start_a[0] = ray_start_x_i;
  assign start_a[1] = ray_start_y_i;
  assign start_a[2] = ray_start_z_i;
  assign dir_a[0]   = ray_dir_x_i;
  assign dir_a[1]   = ray_dir_y_i;
  assign dir_a[2]   = ray_dir_z_i;
  assign nrm_a[0]   = plane_normal_x_i;
  assign nrm_a[1]   = plane_normal_y_i;
  assign nrm_a[2]   = plane_normal_z_i;

  logic                     v1_q;
  logic signed [PROD_W-1:0] pnd_q [3];
  logic signed [PROD_W-1:0] pns_q [3];
  logic [2:0][CW-1:0]       start1_q, dir1_q;
  logic [CW-1:0]            off1_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pnd_q[i]    <= nrm_a[i] * dir_a[i];
      pns_q[i]    <= nrm_a[i] * start_a[i];
      start1_q[i] <= start_a[i];
      dir1_q[i]   <= dir_a[i];
    end
    off1_q <= plane_offset_i;
  end

  // ---------------- stage 2: floor-shift and sum ----------------
  logic [SH_W-1:0]        shd [3];
  logic [SH_W-1:0]        shs [3];
  logic signed [DOT_W-1:0] d1_d, ns_d;
  logic signed [REM_W-1:0] dist_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shd[i] = pnd_q[i][PROD_W-1:FRAC_BITS];
      shs[i] = pns_q[i][PROD_W-1:FRAC_BITS];
    end
    d1_d = {{2{shd[0][SH_W-1]}}, shd[0]} + {{2{shd[1][SH_W-1]}}, shd[1]}
         + {{2{shd[2][SH_W-1]}}, shd[2]};
    ns_d = {{2{shs[0][SH_W-1]}}, shs[0]} + {{2{shs[1][SH_W-1]}}, shs[1]}
         + {{2{shs[2][SH_W-1]}}, shs[2]};
    dist_d = {ns_d[DOT_W-1], ns_d} - {{(REM_W-CW){off1_q[CW-1]}}, off1_q};
  end

  logic                    v2_q;
  logic signed [DOT_W-1:0] d1_q;
  logic signed [REM_W-1:0] dist_q;
  logic [2:0][CW-1:0]      start2_q, dir2_q;

  always_ff @(posedge clk_i) begin
    d1_q     <= d1_d;
    dist_q   <= dist_d;
    start2_q <= start1_q;
    dir2_q   <= dir1_q;
  end

  // ---------------- stage 3: classify, form numerator and divisor ----------------
  logic [DOT_W:0]   d1e;
  logic             facing_miss;
  rpi_pkg::miss_e   miss_d;
  logic [REM_W-1:0] den_d;

  always_comb begin
    d1e = {d1_q[DOT_W-1], d1_q} + {{(DOT_W+1-EW){1'b0}}, eps_q};
    // d1 >= 0, or d1 + eps > 0
    facing_miss = !d1_q[DOT_W-1] || (!d1e[DOT_W] && (d1e != '0));
    if (facing_miss) begin
      miss_d = rpi_pkg::MISS_FACING;
    end else if (dist_q[REM_W-1]) begin
      miss_d = rpi_pkg::MISS_BEHIND;
    end else begin
      miss_d = rpi_pkg::MISS_NONE;
    end
    den_d = REM_W'(0) - {d1_q[DOT_W-1], d1_q};
  end

  logic               v3_q;
  logic [REM_W-1:0]   num3_q, den3_q;
  rpi_pkg::miss_e     miss3_q;
  logic [2:0][CW-1:0] start3_q, dir3_q;

  always_ff @(posedge clk_i) begin
    num3_q   <= dist_q;
    den3_q   <= den_d;
    miss3_q  <= miss_d;
    start3_q <= start2_q;
    dir3_q   <= dir2_q;
  end

  // ---------------- stage 4: overflow check, divider setup ----------------
  logic                      ovf_d;
  logic [REM_W+FRAC_BITS-1:0] nfull;

  // integer part of num / den reaches 2^(31-FRAC_BITS)
  assign ovf_d = {{SHF{1'b0}}, num3_q} >= {den3_q, {SHF{1'b0}}};
  assign nfull = {num3_q, {FRAC_BITS{1'b0}}};

  // divider pipeline, index k is the input of step k
  logic             dv_q   [QW+1];
  logic [REM_W-1:0] dr_q   [QW+1];
  logic [QW-1:0]    dlow_q [QW+1];
  logic [QW-1:0]    dqt_q  [QW+1];
  logic [REM_W-1:0] dden_q [QW+1];
  side_t            dside_q[QW+1];

  always_ff @(posedge clk_i) begin
    dr_q[0]          <= {{(REM_W-R0_W){1'b0}}, nfull[REM_W+FRAC_BITS-1:QW]};
    dlow_q[0]        <= nfull[QW-1:0];
    dqt_q[0]         <= '0;
    dden_q[0]        <= den3_q;
    dside_q[0].start <= start3_q;
    dside_q[0].dir   <= dir3_q;
    dside_q[0].miss  <= miss3_q;
    dside_q[0].ovf   <= ovf_d;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [REM_W:0]   r_sh;
    logic [REM_W+1:0] diff;

    assign r_sh = {dr_q[k], dlow_q[k][QW-1]};
    assign diff = {1'b0, r_sh} - {2'b00, dden_q[k]};

    always_ff @(posedge clk_i) begin
      if (!diff[REM_W+1]) begin
        dr_q[k+1]  <= diff[REM_W-1:0];
        dqt_q[k+1] <= {dqt_q[k][QW-2:0], 1'b1};
      end else begin
        dr_q[k+1]  <= r_sh[REM_W-1:0];
        dqt_q[k+1] <= {dqt_q[k][QW-2:0], 1'b0};
      end
      dlow_q[k+1]  <= {dlow_q[k][QW-2:0], 1'b0};
      dden_q[k+1]  <= dden_q[k];
      dside_q[k+1] <= dside_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k+1] <= 1'b0;
      end else begin
        dv_q[k+1] <= dv_q[k];
      end
    end
  end

  // ---------------- point stage 1: t * dir ----------------
  logic signed [CW-1:0] t_d;
  assign t_d = dside_q[QW].ovf ? {1'b0, {(CW-1){1'b1}}} : {1'b0, dqt_q[QW]};

  logic                     vp_q;
  logic signed [PROD_W-1:0] ptd_q [3];
  logic signed [CW-1:0]     tp_q;
  logic [2:0][CW-1:0]       startp_q;
  rpi_pkg::miss_e           missp_q;
  logic                     ovfp_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      ptd_q[i] <= t_d * $signed(dside_q[QW].dir[i]);
    end
    tp_q     <= t_d;
    startp_q <= dside_q[QW].start;
    missp_q  <= dside_q[QW].miss;
    ovfp_q   <= dside_q[QW].ovf;
  end

  // ---------------- point stage 2: add, clamp, output ----------------
  logic [SH_W-1:0]       psh  [3];
  logic [SH_W:0]         psum [3];
  logic [CW-1:0]         pclp [3];
  logic [2:0]            pover;
  logic                  sat_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psh[i]  = ptd_q[i][PROD_W-1:FRAC_BITS];
      psum[i] = {psh[i][SH_W-1], psh[i]}
              + {{(SH_W+1-CW){startp_q[i][CW-1]}}, startp_q[i]};
      // in range when every bit above the low CW-1 equals the sign
      pover[i] = (psum[i][SH_W:CW-1] != '0) && (psum[i][SH_W:CW-1] != '1);
      if (!pover[i]) begin
        pclp[i] = psum[i][CW-1:0];
      end else if (psum[i][SH_W]) begin
        pclp[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pclp[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
    sat_d = ovfp_q || (pover != '0);
  end

  logic hit_d;
  assign hit_d = (missp_q == rpi_pkg::MISS_NONE);

  logic done_q;

  always_ff @(posedge clk_i) begin
    hit_o         <= hit_d;
    miss_reason_o <= missp_q;
    hit_distance_o <= hit_d ? tp_q    : '0;
    point_x_o     <= hit_d ? pclp[0] : '0;
    point_y_o     <= hit_d ? pclp[1] : '0;
    point_z_o     <= hit_d ? pclp[2] : '0;
    saturated_o   <= hit_d && sat_d;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      dv_q[0] <= 1'b0;
      vp_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v1_q    <= accept;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      dv_q[0] <= v3_q;
      vp_q    <= dv_q[QW];
      done_q  <= vp_q;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

/* rtl/rpi_checker.sv */
`default_nettype none

module rpi_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               done_o,
  input wire logic                               hit_o,
  input wire logic [1:0]                         miss_reason_o,
  input wire logic [rpi_pkg::COORD_W-1:0]        hit_distance_o,
  input wire logic [rpi_pkg::COORD_W-1:0]        point_x_o,
  input wire logic [rpi_pkg::COORD_W-1:0]        point_y_o,
  input wire logic [rpi_pkg::COORD_W-1:0]        point_z_o,
  input wire logic                               saturated_o
);

  localparam int unsigned LAT = rpi_pkg::PIPE_LAT;

  // a result only ever follows an accepted transfer by the pipeline latency
  a_done_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without matching transfer");

  a_transfer_completes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("transfer produced no result");

  a_hit_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hit_o == (miss_reason_o == rpi_pkg::MISS_NONE)))
    else $error("hit flag disagrees with miss reason");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (hit_distance_o == '0 && point_x_o == '0 &&
                            point_y_o == '0 && point_z_o == '0 && !saturated_o))
    else $error("nonzero numeric result on a miss");

endmodule

bind ray_plane_intersection rpi_checker u_rpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .hit_o         (hit_o),
  .miss_reason_o (miss_reason_o),
  .hit_distance_o(hit_distance_o),
  .point_x_o     (point_x_o),
  .point_y_o     (point_y_o),
  .point_z_o     (point_z_o),
  .saturated_o   (saturated_o)
);

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;

  localparam int unsigned FRAC = rpi_pkg::FRAC_BITS_DEF;
  localparam int unsigned AW   = rpi_pkg::ADDR_W;
  localparam int unsigned DW   = rpi_pkg::DATA_W;
  localparam int unsigned EW   = rpi_pkg::EPS_W;

  // register map: one 32-bit register per word
  localparam logic [AW-1:0] EPS_ADDR    = AW'(4 * rpi_pkg::REG_EPS);
  localparam logic [AW-1:0] UNUSED_ADDR = AW'(4 * (rpi_pkg::REG_EPS + 1));

  typedef logic signed [rpi_pkg::COORD_W-1:0] coord_t;

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;

  typedef struct {
    coord_t start [3];
    coord_t dir [3];
    coord_t nrm [3];
    coord_t off;
  } ray_t;

  typedef struct {
    bit             hit;
    rpi_pkg::miss_e miss_reason;
    coord_t         hit_distance;
    coord_t         point [3];
    bit             saturated;
  } hit_t;

  class plane_hit_ledger;
    logic [EW-1:0] eps;
    hit_t expected_hits [$];
    int unsigned errors;

    function new();
      eps = rpi_pkg::EPS_RESET;
      errors = 0;
    endfunction

    // fixed-point dot product, each product floored before the exact sum
    static function longint dot_q(coord_t a [3], coord_t b [3]);
      longint acc;
      acc = 0;
      for (int i = 0; i < 3; i++) acc += (longint'(a[i]) * longint'(b[i])) >>> FRAC;
      return acc;
    endfunction

    function hit_t predict_hit(ray_t r);
      hit_t h;
      longint d1, gap, t, p;
      logic [63:0] num, den, q, rem, frac;
      bit sat;
      h.hit = 1'b0;
      h.miss_reason = rpi_pkg::MISS_NONE;
      h.hit_distance = '0;
      for (int i = 0; i < 3; i++) h.point[i] = '0;
      h.saturated = 1'b0;
      sat = 1'b0;
      d1 = dot_q(r.nrm, r.dir);
      // d1 == 0 misses even with a zero tolerance
      if (d1 > -longint'(eps) || d1 >= 0) begin
        h.miss_reason = rpi_pkg::MISS_FACING;
        return h;
      end
      gap = dot_q(r.nrm, r.start) - longint'(r.off);
      if (gap < 0) begin
        h.miss_reason = rpi_pkg::MISS_BEHIND;
        return h;
      end
      num = gap;
      den = -d1;
      q = num / den;
      rem = num % den;
      if (q >= (64'd1 << (31 - FRAC))) begin
        t = 64'sd2147483647;
        sat = 1'b1;
      end else begin
        frac = (rem << FRAC) / den;
        t = longint'((q << FRAC) | frac);
      end
      for (int i = 0; i < 3; i++) begin
        p = longint'(r.start[i]) + ((t * longint'(r.dir[i])) >>> FRAC);
        if (p > 64'sd2147483647) begin
          p = 64'sd2147483647;
          sat = 1'b1;
        end else if (p < -64'sd2147483648) begin
          p = -64'sd2147483648;
          sat = 1'b1;
        end
        h.point[i] = coord_t'(p);
      end
      h.hit = 1'b1;
      h.hit_distance = coord_t'(t);
      h.saturated = sat;
      return h;
    endfunction

    function void note_ray(ray_t r);
      expected_hits.push_back(predict_hit(r));
    endfunction

    function void write_reg(logic [AW-1:0] addr, logic [DW-1:0] data);
      if ((addr >> 2) == rpi_pkg::REG_EPS) eps = data[EW-1:0];
    endfunction

    function void check_eps_read(logic [DW-1:0] got);
      logic [DW-1:0] want;
      want = DW'(eps);
      if (got !== want) begin
        errors++;
        $display("%0t: facing_epsilon read expected %0h got %0h", $time, want, got);
      end
    endfunction

    function void check_hit(hit_t got);
      hit_t want;
      longint w [7];
      longint g [7];
      string tag [7];
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no ray pending", $time);
        return;
      end
      want = expected_hits.pop_front();
      w = '{longint'(want.hit), longint'(want.miss_reason), longint'(want.hit_distance),
            longint'(want.point[0]), longint'(want.point[1]), longint'(want.point[2]),
            longint'(want.saturated)};
      g = '{longint'(got.hit), longint'(got.miss_reason), longint'(got.hit_distance),
            longint'(got.point[0]), longint'(got.point[1]), longint'(got.point[2]),
            longint'(got.saturated)};
      tag = '{"hit", "miss_reason", "hit_distance", "point_x", "point_y", "point_z",
              "saturated"};
      foreach (w[i]) begin
        if (w[i] != g[i]) begin
          errors++;
          $display("%0t: %s expected %0d got %0d", $time, tag[i], w[i], g[i]);
        end
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  coord_t ray_start_x, ray_start_y, ray_start_z;
  coord_t ray_dir_x, ray_dir_y, ray_dir_z;
  coord_t plane_normal_x, plane_normal_y, plane_normal_z, plane_offset;
  logic done_o, hit_o, saturated_o;
  logic [1:0] miss_reason_o;
  coord_t hit_distance_o, point_x_o, point_y_o, point_z_o;
  logic psel, penable, pwrite, pready;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata, prdata;

  plane_hit_ledger ledger;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ray_plane_intersection u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .ray_start_x_i    (ray_start_x),
    .ray_start_y_i    (ray_start_y),
    .ray_start_z_i    (ray_start_z),
    .ray_dir_x_i      (ray_dir_x),
    .ray_dir_y_i      (ray_dir_y),
    .ray_dir_z_i      (ray_dir_z),
    .plane_normal_x_i (plane_normal_x),
    .plane_normal_y_i (plane_normal_y),
    .plane_normal_z_i (plane_normal_z),
    .plane_offset_i   (plane_offset),
    .done_o           (done_o),
    .hit_o            (hit_o),
    .miss_reason_o    (miss_reason_o),
    .hit_distance_o   (hit_distance_o),
    .point_x_o        (point_x_o),
    .point_y_o        (point_y_o),
    .point_z_o        (point_z_o),
    .saturated_o      (saturated_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // result side: values seen here are the ones before this edge
  always @(posedge clk_i) begin
    hit_t got;
    if (rst_ni && done_o) begin
      got.hit = hit_o;
      got.miss_reason = rpi_pkg::miss_e'(miss_reason_o);
      got.hit_distance = hit_distance_o;
      got.point[0] = point_x_o;
      got.point[1] = point_y_o;
      got.point[2] = point_z_o;
      got.saturated = saturated_o;
      ledger.check_hit(got);
    end
  end

  function automatic ray_t mk_ray(coord_t sx, coord_t sy, coord_t sz, coord_t dx, coord_t dy,
                                  coord_t dz, coord_t nx, coord_t ny, coord_t nz, coord_t off);
    ray_t r;
    r.start = '{sx, sy, sz};
    r.dir = '{dx, dy, dz};
    r.nrm = '{nx, ny, nz};
    r.off = off;
    return r;
  endfunction

  function automatic coord_t rand_small();
    return coord_t'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  function automatic coord_t rand_mid();
    return coord_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return coord_t'($urandom);
      2: return rand_small();
      3: return rand_mid();
      4: return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      default: begin
        case ($urandom_range(0, 4))
          0: return CMAX;
          1: return CMIN;
          2: return '0;
          3: return coord_t'(1);
          default: return coord_t'(-1);
        endcase
      end
    endcase
  endfunction

  // front-facing ray with the plane ahead; broken ones face away, have a zero direction or start behind
  function automatic ray_t well_formed_ray(bit broken);
    ray_t r;
    longint d1, base;
    for (int i = 0; i < 3; i++) begin
      r.nrm[i] = rand_small();
      r.dir[i] = rand_small();
      r.start[i] = rand_mid();
    end
    case ($urandom_range(0, 7))
      0: r.dir[$urandom_range(0, 2)] = coord_t'($urandom);
      1: r.start[$urandom_range(0, 2)] = coord_t'($urandom);
      default: ;
    endcase
    d1 = plane_hit_ledger::dot_q(r.nrm, r.dir);
    if (d1 >= 0)
      for (int i = 0; i < 3; i++) r.dir[i] = -r.dir[i];
    base = plane_hit_ledger::dot_q(r.nrm, r.start);
    if ($urandom_range(0, 9) == 0) r.off = coord_t'(base);
    else r.off = coord_t'(base - longint'($urandom_range(1, 1 << 22)));
    if (broken) begin
      case ($urandom_range(0, 2))
        0: r.off = coord_t'(base + longint'($urandom_range(1, 1 << 20)));
        1: for (int i = 0; i < 3; i++) r.dir[i] = '0;
        default: for (int i = 0; i < 3; i++) r.dir[i] = -r.dir[i];
      endcase
    end
    return r;
  endfunction

  function automatic ray_t any_ray();
    int unsigned pick;
    ray_t r;
    pick = $urandom_range(0, 99);
    if (pick < 65) return well_formed_ray(1'b0);
    if (pick < 85) begin
      for (int i = 0; i < 3; i++) begin
        r.start[i] = rand_coord();
        r.dir[i] = rand_coord();
        r.nrm[i] = rand_coord();
      end
      r.off = rand_coord();
      return r;
    end
    return well_formed_ray(1'b1);
  endfunction

  // called at a rising edge; returns at the edge that accepts the transfer
  task automatic send_ray(ray_t r);
    start <= 1'b1;
    ray_start_x <= r.start[0];
    ray_start_y <= r.start[1];
    ray_start_z <= r.start[2];
    ray_dir_x <= r.dir[0];
    ray_dir_y <= r.dir[1];
    ray_dir_z <= r.dir[2];
    plane_normal_x <= r.nrm[0];
    plane_normal_y <= r.nrm[1];
    plane_normal_z <= r.nrm[2];
    plane_offset <= r.off;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    ledger.note_ray(r);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [AW-1:0] addr, logic [DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    ledger.write_reg(addr, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic eps_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= EPS_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    ledger.check_eps_read(prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // d1 right at, just past and just short of the facing tolerance
  task automatic tolerance_edges();
    coord_t e;
    e = coord_t'(ledger.eps);
    send_ray(mk_ray(ONE, rand_coord(), rand_coord(), -e, 0, 0, ONE, 0, 0, 0));
    send_ray(mk_ray(ONE, rand_coord(), rand_coord(), -e - 1, 0, 0, ONE, 0, 0, 0));
    send_ray(mk_ray(ONE, rand_coord(), rand_coord(), -e + 1, 0, 0, ONE, 0, 0, 0));
  endtask

  task automatic random_rays(int n, bit gaps);
    bit gapping;
    gapping = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) gapping = gaps && ($urandom_range(0, 2) != 0);
      send_ray(any_ray());
      if (gapping && $urandom_range(0, 5) == 0) idle_burst();
    end
  endtask

  initial begin
    logic [DW-1:0] eps_plan [5];
    start = 1'b0;
    {ray_start_x, ray_start_y, ray_start_z} = '0;
    {ray_dir_x, ray_dir_y, ray_dir_z} = '0;
    {plane_normal_x, plane_normal_y, plane_normal_z, plane_offset} = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ledger = new();
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    eps_readback();

    send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_ray(mk_ray(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_ray(mk_ray(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_ray(mk_ray(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN));
    send_ray(mk_ray(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX));
    send_ray(mk_ray(0, 10 * ONE, 0, 0, -2 * ONE, 0, 0, ONE, 0, 0));
    // start exactly on the plane
    send_ray(mk_ray(3 * ONE, 4 * ONE, 2 * ONE, ONE / 2, ONE / 4, -ONE, 0, 0, ONE, 2 * ONE));
    // one LSB behind the plane, quotient would round to zero
    send_ray(mk_ray(0, 0, 2 * ONE, 0, 0, -1000 * ONE, 0, 0, ONE, 2 * ONE + 1));
    // back facing and behind: facing wins
    send_ray(mk_ray(0, 0, 2 * ONE, 0, 0, ONE, 0, 0, ONE, 3 * ONE));
    send_ray(mk_ray(ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0, 0));
    // t lands just under the clamp, then exactly at it
    send_ray(mk_ray(CMAX, 0, 0, -ONE, 0, 0, ONE, 0, 0, 0));
    send_ray(mk_ray(coord_t'(1 << 30), 0, 0, -32768, 0, 0, ONE, 0, 0, 0));
    send_ray(mk_ray(100 * ONE, 32'sh7fff_0000, 0, -ONE, CMAX, 0, ONE, 0, 0, 0));
    send_ray(mk_ray(100 * ONE, 32'sh8001_0000, 0, -ONE, CMIN, 0, ONE, 0, 0, 0));
    send_ray(mk_ray(0, 0, 0, -ONE, 0, 0, ONE, 0, 0, CMIN));
    send_ray(mk_ray(0, 0, 0, -ONE, 0, 0, ONE, 0, 0, CMAX));
    send_ray(mk_ray(21845, -5, 77777, -3, 7, -11, ONE, ONE, ONE, -12345));
    // LSB-sized products floor toward minus infinity
    send_ray(mk_ray(1, 1, 1, 1, 1, 1, -1, -1, -1, -10));
    tolerance_edges();

    eps_plan = '{32'd0, 32'd65536, DW'($urandom_range(0, 65536)), 32'hfffe_1234, 32'd1};
    foreach (eps_plan[p]) begin
      drain();
      reg_write(EPS_ADDR, eps_plan[p]);
      if (p == 2) reg_write(UNUSED_ADDR, $urandom);
      eps_readback();
      tolerance_edges();
      random_rays(335, 1'b1);
    end
    random_rays(200, 1'b0);

    drain();
    repeat (rpi_pkg::PIPE_LAT + 8) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("ray_plane_intersection regression: pass");
    end else begin
      $display("ray_plane_intersection regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("ray_plane_intersection regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
